/* sv/ptw4_pkg.sv */
// ============================================================================
// ptw4_pkg
// Shared types and constants of the four-level page table walker.
// ============================================================================
package ptw4_pkg;

    // Input opcodes, carried on s_tuser.
    localparam logic OP_START = 1'b0;
    localparam logic OP_ENTRY = 1'b1;

    // Result kinds, carried on m_tuser.
    localparam logic RK_READ = 1'b0;
    localparam logic RK_DONE = 1'b1;

    // Page size codes.
    localparam logic [1:0] PS_4K = 2'd0;
    localparam logic [1:0] PS_2M = 2'd1;
    localparam logic [1:0] PS_1G = 2'd2;

    // Level whose entry is awaited.
    localparam logic [1:0] LVL_PML4 = 2'd3;
    localparam logic [1:0] LVL_PDPT = 2'd2;
    localparam logic [1:0] LVL_PD   = 2'd1;
    localparam logic [1:0] LVL_PT   = 2'd0;

    // Page sizes in bytes, at the width of bytes_left_in_page.
    localparam logic [30:0] SIZE_1G = 31'h4000_0000;
    localparam logic [30:0] SIZE_2M = 31'h0020_0000;
    localparam logic [30:0] SIZE_4K = 31'h0000_1000;

    // Field widths.
    localparam int FRAME_W = 36;
    localparam int VA_W    = 48;
    localparam int ADDR_W  = 48;
    localparam int LEFT_W  = 31;

    // Decoupling queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // A classified input beat. For a start the frame is the root table
    // frame; for an entry it is the entry's frame, both already cut to the
    // physical address width.
    typedef struct packed {
        logic               is_entry;
        logic               present;
        logic               page_size;
        logic [FRAME_W-1:0] frame;
        logic [VA_W-1:0]    va;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] read_addr;
        logic              ok;
        logic [ADDR_W-1:0] phys_addr;
        logic [1:0]        size_code;
        logic [LEFT_W-1:0] left;
    } result_t;

endpackage

/* sv/ptw4_front.sv */
// ============================================================================
// ptw4_front
// Classifies an input beat: separates starts from entries and predecodes
// the present bit, the page size bit and the frame of an entry.
// ============================================================================
module ptw4_front #(
    parameter int PHYS_ADDR_BITS = 48
) (
    input  logic                          opcode,
    input  logic [ptw4_pkg::FRAME_W-1:0]  root_table_frame,
    input  logic [ptw4_pkg::VA_W-1:0]     virtual_address,
    input  logic [63:0]                   entry_word,
    output ptw4_pkg::item_t               item
);

    localparam logic [63:0] PA_MASK64 = (64'd1 << PHYS_ADDR_BITS) - 64'd1;
    localparam logic [ptw4_pkg::FRAME_W-1:0] FRAME_MASK = PA_MASK64[47:12];

    always_comb
    begin
        item.is_entry  = (opcode == ptw4_pkg::OP_ENTRY);
        item.present   = entry_word[0];
        item.page_size = entry_word[7];
        item.va        = virtual_address;
        if (opcode == ptw4_pkg::OP_ENTRY)
        begin
            item.frame = entry_word[47:12] & FRAME_MASK;
        end
        else
        begin
            item.frame = root_table_frame & FRAME_MASK;
        end
    end

endmodule

/* sv/ptw4_queue.sv */
// ============================================================================
// ptw4_queue
// Short first-in first-out queue of classified beats between front and back.
// ============================================================================
module ptw4_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ptw4_pkg::item_t push_item,
    output logic            not_full,
    input  logic            pop,
    output logic            not_empty,
    output ptw4_pkg::item_t head
);

    ptw4_pkg::item_t                  mem_reg [ptw4_pkg::QUEUE_DEPTH];
    logic [ptw4_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ptw4_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ptw4_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign not_full  = (count_reg != ptw4_pkg::QCNT_W'(ptw4_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + ptw4_pkg::QCNT_W'(push) - ptw4_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* sv/ptw4_back.sv */
// ============================================================================
// ptw4_back
// Carries out the walk: holds the walk state, turns each queued beat into a
// read request or a finished translation, and keeps the result register.
// ============================================================================
module ptw4_back #(
    parameter int PHYS_ADDR_BITS = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  ptw4_pkg::item_t   head,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_ready,
    output ptw4_pkg::result_t res
);

    localparam logic [63:0] PA_MASK64 = (64'd1 << PHYS_ADDR_BITS) - 64'd1;
    localparam logic [ptw4_pkg::ADDR_W-1:0] ADDR_MASK = PA_MASK64[47:0];

    logic                        active_reg, active_next;
    logic [1:0]                  level_reg, level_next;
    logic [ptw4_pkg::VA_W-1:0]   va_reg, va_next;
    logic                        res_valid_reg;
    ptw4_pkg::result_t           res_reg, res_next;
    logic                        emit;
    logic                        drop;
    logic                        out_free;
    logic [8:0]                  index;

    assign drop     = head.is_entry && !active_reg;
    assign out_free = !res_valid_reg || res_ready;
    assign pop      = head_valid && (drop || out_free);
    assign emit     = pop && !drop;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        active_next = active_reg;
        level_next  = level_reg;
        va_next     = va_reg;
        res_next    = '0;
        index       = '0;

        priority if (!head.is_entry)
        begin
            active_next        = 1'b1;
            level_next         = ptw4_pkg::LVL_PML4;
            va_next            = head.va;
            res_next.kind      = ptw4_pkg::RK_READ;
            res_next.read_addr = {head.frame, head.va[47:39], 3'b000} & ADDR_MASK;
        end
        else if (!head.present)
        begin
            active_next   = 1'b0;
            level_next    = ptw4_pkg::LVL_PT;
            res_next.kind = ptw4_pkg::RK_DONE;
        end
        else
        begin
            unique case (level_reg)
                ptw4_pkg::LVL_PML4:
                begin
                    index = va_reg[38:30];
                    level_next = ptw4_pkg::LVL_PDPT;
                end
                ptw4_pkg::LVL_PDPT:
                begin
                    index = va_reg[29:21];
                    level_next = ptw4_pkg::LVL_PD;
                end
                ptw4_pkg::LVL_PD:
                begin
                    index = va_reg[20:12];
                    level_next = ptw4_pkg::LVL_PT;
                end
                default:
                begin
                    index = '0;
                    level_next = ptw4_pkg::LVL_PT;
                end
            endcase
            res_next.kind      = ptw4_pkg::RK_READ;
            res_next.read_addr = {head.frame, index, 3'b000} & ADDR_MASK;

            // A terminal entry overrides the request built above.
            if (level_reg == ptw4_pkg::LVL_PDPT && head.page_size)
            begin
                active_next        = 1'b0;
                level_next         = ptw4_pkg::LVL_PT;
                res_next           = '0;
                res_next.kind      = ptw4_pkg::RK_DONE;
                res_next.ok        = 1'b1;
                res_next.phys_addr = {head.frame[35:18], va_reg[29:0]} & ADDR_MASK;
                res_next.size_code = ptw4_pkg::PS_1G;
                res_next.left      = ptw4_pkg::SIZE_1G - {1'b0, va_reg[29:0]};
            end
            else if (level_reg == ptw4_pkg::LVL_PD && head.page_size)
            begin
                active_next        = 1'b0;
                level_next         = ptw4_pkg::LVL_PT;
                res_next           = '0;
                res_next.kind      = ptw4_pkg::RK_DONE;
                res_next.ok        = 1'b1;
                res_next.phys_addr = {head.frame[35:9], va_reg[20:0]} & ADDR_MASK;
                res_next.size_code = ptw4_pkg::PS_2M;
                res_next.left      = ptw4_pkg::SIZE_2M - {10'b0, va_reg[20:0]};
            end
            else if (level_reg == ptw4_pkg::LVL_PT)
            begin
                active_next        = 1'b0;
                res_next           = '0;
                res_next.kind      = ptw4_pkg::RK_DONE;
                res_next.ok        = 1'b1;
                res_next.phys_addr = {head.frame, va_reg[11:0]} & ADDR_MASK;
                res_next.size_code = ptw4_pkg::PS_4K;
                res_next.left      = ptw4_pkg::SIZE_4K - {19'b0, va_reg[11:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            level_reg     <= ptw4_pkg::LVL_PT;
            va_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                active_reg <= active_next;
                level_reg  <= level_next;
                va_reg     <= va_next;
            end
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

endmodule

/* sv/four_level_page_table_walker.sv */
// ============================================================================
// four_level_page_table_walker
// Walks x86-64 four-level page tables, one input beat at a time.
// ============================================================================
// An accepted beat is written into the queue, then loaded into the result register
// at the head of the queue when the master side is free. Throughput: one input
// beat per cycle while the queue has room; the back part, when the result register
// is free, decodes one queued beat per cycle in a single step, so nothing iterates.
// Reset (rst_n low) empties the queue, drops the result register and leaves
// the walker idle with no walk in progress.
module four_level_page_table_walker #(
    parameter int PHYS_ADDR_BITS = 48
) (
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    // From bit 0: root_table_frame[35:0], virtual_address[83:36],
    // entry_word[147:84], zero padding[151:148].
    input  logic [151:0] s_tdata,
    // Bit 0: opcode (0 start a translation, 1 entry returned from memory).
    input  logic [0:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // From bit 0: entry_read_address[47:0], translation_ok[48],
    // physical_address[96:49], page_size_code[98:97],
    // bytes_left_in_page[129:99], zero padding[135:130].
    output logic [135:0] m_tdata,
    // Bit 0: result_kind (0 read request, 1 translation finished).
    output logic [0:0]   m_tuser
);

    // The front part classifies each beat on the way into the queue.
    // Starts carry the root frame and the virtual address, entries carry a
    // predecoded present bit, page size bit and frame.
    ptw4_pkg::item_t   front_item;
    ptw4_pkg::item_t   head_item;
    ptw4_pkg::result_t result;
    logic              q_not_full;
    logic              q_not_empty;
    logic              q_pop;
    logic              in_beat;

    assign s_tready = q_not_full;
    assign in_beat  = s_tvalid && s_tready;

    ptw4_front #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_front (
        .opcode           (s_tuser[0]),
        .root_table_frame (s_tdata[35:0]),
        .virtual_address  (s_tdata[83:36]),
        .entry_word       (s_tdata[147:84]),
        .item             (front_item)
    );

    // The queue lets the front keep taking beats while the result register
    // waits on a stalled master side.
    ptw4_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_beat),
        .push_item (front_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_item)
    );

    // The back part owns the walk state. An entry that arrives while no walk
    // is active is consumed without a result; every other beat yields exactly
    // one result beat.
    ptw4_back #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_not_empty),
        .head       (head_item),
        .pop        (q_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (result)
    );

    assign m_tuser[0] = result.kind;
    assign m_tdata    = {6'b0, result.left, result.size_code, result.phys_addr,
                         result.ok, result.read_addr};

endmodule

/* sv/ptw4_checker.sv */
// ============================================================================
// ptw4_checker
// Port-level checks on the result stream of the page table walker.
// ============================================================================
module ptw4_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A read request carries only an address.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == ptw4_pkg::RK_READ |-> m_tdata[135:48] == '0)
        else $error("read request carries translation fields");

    // A fault carries nothing but its kind.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == ptw4_pkg::RK_DONE && !m_tdata[48]
        |-> m_tdata == '0)
        else $error("fault carries non-zero fields");

    // A successful translation has a legal size and a byte count within it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == ptw4_pkg::RK_DONE && m_tdata[48]
        |-> m_tdata[47:0] == '0 && m_tdata[129:99] != '0
            && ((m_tdata[98:97] == ptw4_pkg::PS_4K && m_tdata[129:99] <= ptw4_pkg::SIZE_4K)
             || (m_tdata[98:97] == ptw4_pkg::PS_2M && m_tdata[129:99] <= ptw4_pkg::SIZE_2M)
             || (m_tdata[98:97] == ptw4_pkg::PS_1G && m_tdata[129:99] <= ptw4_pkg::SIZE_1G)))
        else $error("finished translation has a bad size or byte count");

endmodule

bind four_level_page_table_walker ptw4_checker u_ptw4_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* sim/ptw4_walk_checker.sv */
// ============================================================================
// ptw4_walk_checker
// Watches both streams of the page table walker. It predicts each result beat
// from the accepted input beats and compares the results field by field.
// ============================================================================
module ptw4_walk_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [151:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic [0:0]   m_tuser,
    output int           mismatch_count,
    output int           pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // This is the checker's own picture of the walk in progress.
    bit          walking;
    logic [1:0]  awaited_level;
    logic [47:0] held_va;

    ptw4_pkg::result_t expected_results[$];
    int                mismatches;

    // Works out the result, if any, that one input beat causes.
    task automatic decode_walk_beat(input logic op, input logic [35:0] root,
                                    input logic [47:0] va, input logic [63:0] entry,
                                    output bit produced, output ptw4_pkg::result_t res);
        logic [35:0] frame;
        frame    = entry[47:12];
        res      = '0;
        produced = 1'b1;
        if (op == ptw4_pkg::OP_START)
        begin
            held_va       = va;
            walking       = 1'b1;
            awaited_level = ptw4_pkg::LVL_PML4;
            res.kind      = ptw4_pkg::RK_READ;
            res.read_addr = {root, va[47:39], 3'b000};
        end
        else if (!walking)
        begin
            produced = 1'b0;
        end
        else if (!entry[0])
        begin
            // A missing entry at any level ends the walk with a fault.
            walking       = 1'b0;
            awaited_level = ptw4_pkg::LVL_PT;
            res.kind      = ptw4_pkg::RK_DONE;
        end
        else
        begin
            case (awaited_level)
                ptw4_pkg::LVL_PML4:
                begin
                    // The page size bit means nothing at this level.
                    awaited_level = ptw4_pkg::LVL_PDPT;
                    res.kind      = ptw4_pkg::RK_READ;
                    res.read_addr = {frame, held_va[38:30], 3'b000};
                end
                ptw4_pkg::LVL_PDPT:
                begin
                    if (entry[7])
                    begin
                        walking       = 1'b0;
                        awaited_level = ptw4_pkg::LVL_PT;
                        res.kind      = ptw4_pkg::RK_DONE;
                        res.ok        = 1'b1;
                        res.phys_addr = {entry[47:30], held_va[29:0]};
                        res.size_code = ptw4_pkg::PS_1G;
                        res.left      = ptw4_pkg::SIZE_1G - {1'b0, held_va[29:0]};
                    end
                    else
                    begin
                        awaited_level = ptw4_pkg::LVL_PD;
                        res.kind      = ptw4_pkg::RK_READ;
                        res.read_addr = {frame, held_va[29:21], 3'b000};
                    end
                end
                ptw4_pkg::LVL_PD:
                begin
                    if (entry[7])
                    begin
                        walking       = 1'b0;
                        awaited_level = ptw4_pkg::LVL_PT;
                        res.kind      = ptw4_pkg::RK_DONE;
                        res.ok        = 1'b1;
                        res.phys_addr = {entry[47:21], held_va[20:0]};
                        res.size_code = ptw4_pkg::PS_2M;
                        res.left      = ptw4_pkg::SIZE_2M - {10'd0, held_va[20:0]};
                    end
                    else
                    begin
                        awaited_level = ptw4_pkg::LVL_PT;
                        res.kind      = ptw4_pkg::RK_READ;
                        res.read_addr = {frame, held_va[20:12], 3'b000};
                    end
                end
                default:
                begin
                    walking       = 1'b0;
                    awaited_level = ptw4_pkg::LVL_PT;
                    res.kind      = ptw4_pkg::RK_DONE;
                    res.ok        = 1'b1;
                    res.phys_addr = {frame, held_va[11:0]};
                    res.size_code = ptw4_pkg::PS_4K;
                    res.left      = ptw4_pkg::SIZE_4K - {19'd0, held_va[11:0]};
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ptw4_pkg::result_t got;
        ptw4_pkg::result_t want;
        ptw4_pkg::result_t predicted;
        bit                produced;
        if (!rst_n)
        begin
            walking       = 1'b0;
            awaited_level = ptw4_pkg::LVL_PT;
            held_va       = '0;
            expected_results.delete();
            mismatches    = 0;
        end
        else
        begin
            // Results are taken first: a result beat leaving at this edge
            // always belongs to an input beat accepted earlier.
            if (m_tvalid && m_tready)
            begin
                got.kind      = m_tuser[0];
                got.read_addr = m_tdata[47:0];
                got.ok        = m_tdata[48];
                got.phys_addr = m_tdata[96:49];
                got.size_code = m_tdata[98:97];
                got.left      = m_tdata[129:99];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with none expected, tuser %h tdata %h",
                                 $realtime, m_tuser, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("result_kind", 64'(want.kind), 64'(got.kind));
                    check_field("entry_read_address", 64'(want.read_addr),
                                64'(got.read_addr));
                    check_field("translation_ok", 64'(want.ok), 64'(got.ok));
                    check_field("physical_address", 64'(want.phys_addr),
                                64'(got.phys_addr));
                    check_field("page_size_code", 64'(want.size_code),
                                64'(got.size_code));
                    check_field("bytes_left_in_page", 64'(want.left), 64'(got.left));
                    check_field("tdata padding", 64'd0, 64'(m_tdata[135:130]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_walk_beat(s_tuser[0], s_tdata[35:0], s_tdata[83:36],
                                 s_tdata[147:84], produced, predicted);
                if (produced)
                    expected_results.push_back(predicted);
            end
        end
        mismatch_count <= mismatches;
        pending_count  <= expected_results.size();
    end

endmodule

/* sim/tb_four_level_page_table_walker.sv */
// ============================================================================
// tb_four_level_page_table_walker
// Drives translate and entry beats into the page table walker, with bursty
// input, a stalling receiver and one long hold-off, and gives the verdict.
// ============================================================================
module tb_four_level_page_table_walker;

    timeunit 1ns;
    timeprecision 1ps;

    // Far beyond what the slowest correct run needs for the whole stimulus.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int WALK_BEATS   = 500;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 8;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // From bit 0: root_table_frame[35:0], virtual_address[83:36],
    // entry_word[147:84], zero padding[151:148].
    logic [151:0] s_tdata  = '0;
    // Bit 0: opcode.
    logic [0:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // From bit 0: entry_read_address[47:0], translation_ok[48],
    // physical_address[96:49], page_size_code[98:97],
    // bytes_left_in_page[129:99], zero padding[135:130].
    logic [135:0] m_tdata;
    // Bit 0: result_kind.
    logic [0:0]   m_tuser;

    int mismatch_count;
    int pending_count;
    int cycle_count  = 0;
    int burst_left   = 0;
    int beats_sent   = 0;
    bit hold_request = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    four_level_page_table_walker u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ptw4_walk_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    function automatic logic [35:0] rand_frame();
        return 36'({$urandom, $urandom});
    endfunction

    function automatic logic [47:0] rand_va();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Offers one beat and returns at the edge where it is accepted. The
    // sender works in bursts; a gap between bursts drops tvalid for a random
    // number of cycles. Within a burst tvalid stays high from one beat to
    // the next, so it is never lowered and raised in the same step.
    task automatic send_beat(input logic op, input logic [35:0] root,
                             input logic [47:0] va, input logic [63:0] entry);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, entry, va, root};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_start(input logic [35:0] root, input logic [47:0] va);
        send_beat(ptw4_pkg::OP_START, root, va, rand_word());
        beats_sent++;
    endtask

    // Entry beats that the walker is expected to act on count as stimulus;
    // those sent while it is idle do not.
    task automatic send_entry(input logic [63:0] entry, input bit counted);
        send_beat(ptw4_pkg::OP_ENTRY, rand_frame(), rand_va(), entry);
        if (counted)
            beats_sent++;
    endtask

    // One translation with random content. Most entries are present, the
    // page size bit is set often enough at the two levels where it ends the
    // walk, and now and then a walk is abandoned so the next start drops it.
    task automatic random_walk();
        logic [47:0] va;
        logic [63:0] entry;
        logic [1:0]  level;
        bit          active;
        va = rand_va();
        case ($urandom_range(0, 7))
            0:       va[29:0] = '0;
            1:       va[29:0] = '1;
            default: ;
        endcase
        send_start(rand_frame(), va);
        level  = ptw4_pkg::LVL_PML4;
        active = 1'b1;
        while (active)
        begin
            if ($urandom_range(0, 19) == 0)
                break;
            entry    = rand_word();
            entry[0] = ($urandom_range(0, 11) != 0);
            if (level == ptw4_pkg::LVL_PDPT || level == ptw4_pkg::LVL_PD)
                entry[7] = ($urandom_range(0, 2) == 0);
            send_entry(entry, 1'b1);
            if (!entry[0] || level == ptw4_pkg::LVL_PT ||
                ((level == ptw4_pkg::LVL_PDPT || level == ptw4_pkg::LVL_PD) && entry[7]))
                active = 1'b0;
            else
                level = level - 2'd1;
        end
        // A stray entry after the walk has ended must be ignored.
        if (!active && $urandom_range(0, 7) == 0)
            send_entry(rand_word(), 1'b0);
    endtask

    // Receiver: stalls on randomly chosen patterns that change from mode to mode, and
    // once, when asked, holds off for a long stretch so that the walker's
    // queue fills and it stops taking input.
    initial
    begin
        int mode;
        int mode_left;
        int phase;
        bit hold_served;
        mode        = 0;
        mode_left   = 0;
        phase       = 0;
        hold_served = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request && !hold_served)
            begin
                hold_served = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                phase++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= (phase % 4 != 3);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Watchdog: a run that has not finished by now has hung.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An entry before any walk has started is ignored.
        send_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);

        // All-ones entries: the page size bit at the top level is ignored,
        // then a 1 GiB page is taken with the whole page left to run.
        send_start(36'hF_FFFF_FFFF, 48'hFFFF_C000_0000);
        send_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_entry(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

        // Smallest values: a full walk down to a 4 KiB page at address zero.
        send_start(36'h0, 48'h0);
        send_entry(64'h1, 1'b1);
        send_entry(64'h1, 1'b1);
        send_entry(64'h1, 1'b1);
        send_entry(64'h1, 1'b1);

        // A 2 MiB page whose entry has the no-execute bit, bits above the
        // physical width and the reserved low frame bits all set; the
        // address sits on the last byte of the page.
        send_start(36'hF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_entry(64'h0000_0000_0000_0003, 1'b1);
        send_entry(64'h8000_0000_0000_1003, 1'b1);
        send_entry(64'hFFF0_ABCD_EFFF_F081, 1'b1);

        // A fault at the top level, the entry having every other bit set.
        send_start(36'h8_0000_0001, 48'h8000_0000_0000);
        send_entry(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);

        // A new translation while a walk is in progress drops the old one;
        // the new walk then faults at the last level.
        send_start(36'h1_2345_6789, 48'h1234_5678_9ABC);
        send_entry(64'h0000_7654_3210_0001, 1'b1);
        send_start(36'h0_0000_1000, 48'h7FFF_FFFF_F000);
        send_entry(64'h7FFF_FFFF_FFFF_F001, 1'b1);
        send_entry(64'h0000_0000_0000_0001, 1'b1);
        send_entry(64'h0000_FFFF_FFFF_F07F, 1'b1);
        send_entry(64'hFFFF_FFFF_FFFF_FFF0, 1'b1);

        // An entry after a finished walk is ignored too.
        send_entry(64'h0000_0000_0000_0081, 1'b0);

        // Random walks; early on the receiver holds off for a long stretch
        // while the sender keeps offering beats.
        hold_request = 1'b1;
        while (beats_sent < WALK_BEATS)
            random_walk();
        s_tvalid <= 1'b0;

        // The checker's count is registered; let it take in the last accepted beat.
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
